FILE: design/sle_pkg.sv
// Shared types and constants for the string literal escaper.
// Used by the interfaces, front end, queue and back end. No dependencies.
package sle_pkg;

  localparam int CHAR_W  = 21;
  localparam int CMD_W   = 2;
  localparam int NDIG_W  = 3;
  localparam int IDX_W   = 4;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHAR  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // How the back end expands one queued entry.
  typedef enum logic [1:0] {
    K_RAW  = 2'd0,
    K_PAIR = 2'd1,
    K_HEX  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    char_t             value;
    logic [NDIG_W-1:0] ndig;
  } desc_t;

  localparam char_t CH_BSL   = 21'h5C;
  localparam char_t CH_QUOTE = 21'h22;
  localparam char_t CH_X     = 21'h78;
  localparam char_t CH_SEMI  = 21'h3B;
  localparam char_t CH_ZERO  = 21'h30;
  localparam char_t CH_UPPER = 21'h37;  // 'A' - 10

  localparam char_t CTRL_LIM = 21'h20;
  localparam char_t HEX_DEL  = 21'h7F;
  localparam char_t HEX_PAD  = 21'h80;
  localparam char_t HEX_SURL = 21'hD7FF;
  localparam char_t HEX_PUA  = 21'hE000;
  localparam char_t HEX_MAX  = 21'h10FFFF;

  // Letter after the backslash for two-character escapes, 0 when none.
  function automatic char_t pair_letter(input char_t c);
    char_t r;
    unique case (c)
      21'h5C:  r = 21'h5C;
      21'h22:  r = 21'h22;
      21'h0A:  r = 21'h6E;
      21'h07:  r = 21'h61;
      21'h08:  r = 21'h62;
      21'h09:  r = 21'h74;
      21'h0B:  r = 21'h76;
      21'h0D:  r = 21'h72;
      21'h0C:  r = 21'h66;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic char_t hex_ascii(input logic [3:0] d);
    char_t r;
    if (d < 4'd10) begin
      r = CH_ZERO + {17'd0, d};
    end else begin
      r = CH_UPPER + {17'd0, d};
    end
    return r;
  endfunction

endpackage

FILE: design/sle_if.sv
// Valid/ready channel interfaces for the string literal escaper.
// Depends on sle_pkg for field widths.
interface sle_in_if;
  logic                      valid;
  logic                      ready;
  logic [sle_pkg::CMD_W-1:0] command;
  sle_pkg::char_t            code_point;
  modport source(output valid, command, code_point, input ready);
  modport sink(input valid, command, code_point, output ready);
endinterface

interface sle_out_if;
  logic           valid;
  logic           ready;
  sle_pkg::char_t out_char;
  logic           last;
  modport source(output valid, out_char, last, input ready);
  modport sink(input valid, out_char, last, output ready);
endinterface

interface sle_cfg_if;
  logic valid;
  logic ready;
  logic display_mode;
  modport source(output valid, display_mode, input ready);
  modport sink(input valid, display_mode, output ready);
endinterface

FILE: design/sle_front.sv
// Front end: accepts input beats, holds the mode register, classifies items.
// Depends on sle_pkg and sle_if; feeds sle_queue.
module sle_front (
  input  logic             clk,
  input  logic             rst_n,
  sle_in_if.sink           in_bus,
  sle_cfg_if.sink          cfg_bus,
  input  logic             q_full,
  output logic             q_push,
  output sle_pkg::desc_t   q_data
);

  logic             display_mode_r;
  sle_pkg::char_t   cp;
  sle_pkg::char_t   letter;
  logic             needs_hex;
  logic             emits;
  logic [sle_pkg::NDIG_W-1:0] ndig;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_mode_r <= 1'b0;
    end else if (cfg_bus.valid) begin
      display_mode_r <= cfg_bus.display_mode;
    end
  end

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = !q_full;

  assign cp        = in_bus.code_point;
  assign letter    = sle_pkg::pair_letter(cp);
  assign needs_hex = (cp < sle_pkg::CTRL_LIM) || (cp == sle_pkg::HEX_DEL) ||
                     (cp == sle_pkg::HEX_PAD) || (cp == sle_pkg::HEX_SURL) ||
                     (cp == sle_pkg::HEX_PUA) || (cp == sle_pkg::HEX_MAX);

  always_comb begin
    priority if (cp[20] != 1'b0) begin
      ndig = 3'd6;
    end else if (cp[19:16] != 4'd0) begin
      ndig = 3'd5;
    end else if (cp[15:12] != 4'd0) begin
      ndig = 3'd4;
    end else if (cp[11:8] != 4'd0) begin
      ndig = 3'd3;
    end else if (cp[7:4] != 4'd0) begin
      ndig = 3'd2;
    end else begin
      ndig = 3'd1;
    end
  end

  always_comb begin
    emits         = 1'b0;
    q_data.kind   = sle_pkg::K_RAW;
    q_data.value  = cp;
    q_data.ndig   = ndig;
    unique case (sle_pkg::cmd_t'(in_bus.command))
      sle_pkg::CMD_CHAR: begin
        emits = 1'b1;
        if (!display_mode_r) begin
          if (letter != '0) begin
            q_data.kind  = sle_pkg::K_PAIR;
            q_data.value = letter;
          end else if (needs_hex) begin
            q_data.kind  = sle_pkg::K_HEX;
          end
        end
      end
      sle_pkg::CMD_BEGIN, sle_pkg::CMD_END: begin
        emits        = !display_mode_r;
        q_data.value = sle_pkg::CH_QUOTE;
      end
      default: begin
        emits = 1'b0;
      end
    endcase
  end

  assign q_push = in_bus.valid && in_bus.ready && emits;

endmodule

FILE: design/sle_queue.sv
// Short FIFO of classified entries between front and back end.
// Depends on sle_pkg.
module sle_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sle_pkg::desc_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sle_pkg::desc_t head
);

  sle_pkg::desc_t                 mem_r [sle_pkg::QDEPTH];
  logic [sle_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [sle_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [sle_pkg::QCNT_W-1:0]     count_r, count_nxt;

  localparam logic [sle_pkg::QPTR_W-1:0] PTR_LAST = sle_pkg::QPTR_W'(sle_pkg::QDEPTH - 1);
  localparam logic [sle_pkg::QCNT_W-1:0] CNT_FULL = sle_pkg::QCNT_W'(sle_pkg::QDEPTH);

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/sle_back.sv
// Back end: expands the queue head into output beats through an output register.
// Depends on sle_pkg and sle_if; reads from sle_queue.
module sle_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  sle_pkg::desc_t head,
  output logic           pop,
  sle_out_if.source      out_bus
);

  logic [sle_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                      out_valid_r;
  sle_pkg::char_t            out_char_r;
  logic                      out_last_r;
  logic                      load;
  sle_pkg::char_t            elem_char;
  logic                      elem_last;
  logic [sle_pkg::IDX_W-1:0] semi_idx;
  logic [sle_pkg::IDX_W-1:0] nib_sum;
  logic [2:0]                nib_sel;
  logic [3:0]                nibble;

  assign semi_idx = {1'b0, head.ndig} + 4'd2;
  assign nib_sum  = {1'b0, head.ndig} + 4'd1 - idx_r;
  assign nib_sel  = nib_sum[2:0];

  always_comb begin
    unique case (nib_sel)
      3'd0:    nibble = head.value[3:0];
      3'd1:    nibble = head.value[7:4];
      3'd2:    nibble = head.value[11:8];
      3'd3:    nibble = head.value[15:12];
      3'd4:    nibble = head.value[19:16];
      3'd5:    nibble = {3'd0, head.value[20]};
      default: nibble = 4'd0;
    endcase
  end

  always_comb begin
    elem_char = head.value;
    elem_last = 1'b1;
    unique case (head.kind)
      sle_pkg::K_PAIR: begin
        if (idx_r == '0) begin
          elem_char = sle_pkg::CH_BSL;
          elem_last = 1'b0;
        end
      end
      sle_pkg::K_HEX: begin
        priority if (idx_r == '0) begin
          elem_char = sle_pkg::CH_BSL;
          elem_last = 1'b0;
        end else if (idx_r == 4'd1) begin
          elem_char = sle_pkg::CH_X;
          elem_last = 1'b0;
        end else if (idx_r == semi_idx) begin
          elem_char = sle_pkg::CH_SEMI;
        end else begin
          elem_char = sle_pkg::hex_ascii(nibble);
          elem_last = 1'b0;
        end
      end
      default: begin
        elem_char = head.value;
        elem_last = 1'b1;
      end
    endcase
  end

  assign load    = head_valid && (!out_valid_r || out_bus.ready);
  assign pop     = load && elem_last;
  assign idx_nxt = pop ? '0 : idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= idx_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= elem_char;
      out_last_r <= elem_last;
    end
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.out_char = out_char_r;
  assign out_bus.last     = out_last_r;

  // mid-expansion the head entry must still be in the queue
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != '0 |-> head_valid)
    else $error("expansion index set with empty queue");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> idx_r == '0)
    else $error("last beat pending but index not cleared");

  a_mid_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> idx_r != '0)
    else $error("non-last beat pending but index cleared");

  a_hex_len: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid && head.kind == sle_pkg::K_HEX |-> head.ndig != 3'd0 && head.ndig <= 3'd6)
    else $error("hex entry with bad digit count");

endmodule

FILE: design/string_literal_escaper_unit.sv
// Top level of the string literal escaper: front end, queue, back end.
// Depends on sle_pkg, sle_if, sle_front, sle_queue and sle_back.
//
//   channel  dir  beat contents
//   in_bus   in   command, code_point
//   out_bus  out  out_char, last
//   cfg_bus  in   display_mode (always ready)
//
// One input beat per cycle; each item yields 0, 1, 2 or 4 to 9 output beats,
// one per cycle, set by the single output register in the back end.
// A two-entry queue lets input continue while a long escape is draining.
// Synchronous active-low reset clears mode, queue and output valid; no sweep.
// Output stalls hold the register; input stalls only when the queue is full.
module string_literal_escaper_unit (
  input  logic       clk,
  input  logic       rst_n,
  sle_in_if.sink     in_bus,
  sle_out_if.source  out_bus,
  sle_cfg_if.sink    cfg_bus
);

  logic           q_full;
  logic           q_push;
  sle_pkg::desc_t q_data;
  logic           q_pop;
  logic           q_head_valid;
  sle_pkg::desc_t q_head;

  sle_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .cfg_bus (cfg_bus),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  sle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  sle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_bus    (out_bus)
  );

endmodule

FILE: sim/tb.sv
// Self-checking bench for string_literal_escaper_unit: directed escapes, then
// random begin/char/end strings in both modes under bursty input and output stalls.
// Depends on sle_pkg, sle_if and the design files.
module tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 40;

  typedef struct {
    sle_pkg::char_t ch;
    logic           last;
  } beat_t;

  typedef struct {
    sle_pkg::cmd_t  cmd;
    sle_pkg::char_t cp;
  } item_t;

  class escape_scoreboard;
    beat_t pending_beats[$];
    int    mismatches = 0;
    int    checked = 0;

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 20) begin
        $display("MISMATCH: %s", msg);
      end
    endtask

    function sle_pkg::char_t esc_letter(sle_pkg::char_t c);
      case (c)
        21'h5C:  return 21'h5C;
        21'h22:  return 21'h22;
        21'h0A:  return 21'h6E;
        21'h07:  return 21'h61;
        21'h08:  return 21'h62;
        21'h09:  return 21'h74;
        21'h0B:  return 21'h76;
        21'h0D:  return 21'h72;
        21'h0C:  return 21'h66;
        default: return '0;
      endcase
    endfunction

    function bit needs_hex_escape(sle_pkg::char_t c);
      return c < sle_pkg::CTRL_LIM || c == sle_pkg::HEX_DEL || c == sle_pkg::HEX_PAD ||
             c == sle_pkg::HEX_SURL || c == sle_pkg::HEX_PUA || c == sle_pkg::HEX_MAX;
    endfunction

    // Expected printed form of one accepted input beat.
    function void note_item(sle_pkg::cmd_t cmd, sle_pkg::char_t cp, logic mode);
      beat_t          beats[$];
      beat_t          b;
      sle_pkg::char_t letter;
      int             digits;
      logic [3:0]     d;
      b.last = 1'b0;
      case (cmd)
        sle_pkg::CMD_CHAR: begin
          letter = esc_letter(cp);
          if (mode) begin
            b.ch = cp; beats.push_back(b);
          end else if (letter != '0) begin
            b.ch = sle_pkg::CH_BSL; beats.push_back(b);
            b.ch = letter; beats.push_back(b);
          end else if (needs_hex_escape(cp)) begin
            digits = 1;
            while (digits < 6 && (cp >> (4 * digits)) != 0) digits++;
            b.ch = sle_pkg::CH_BSL; beats.push_back(b);
            b.ch = sle_pkg::CH_X; beats.push_back(b);
            for (int k = digits - 1; k >= 0; k--) begin
              d = 4'(cp >> (4 * k));
              b.ch = (d < 4'd10) ? 21'h30 + d : 21'h41 + (d - 4'd10);
              beats.push_back(b);
            end
            b.ch = sle_pkg::CH_SEMI; beats.push_back(b);
          end else begin
            b.ch = cp; beats.push_back(b);
          end
        end
        sle_pkg::CMD_BEGIN, sle_pkg::CMD_END: begin
          if (!mode) begin
            b.ch = sle_pkg::CH_QUOTE; beats.push_back(b);
          end
        end
        default: ;
      endcase
      if (beats.size() > 0) beats[beats.size()-1].last = 1'b1;
      foreach (beats[i]) pending_beats.push_back(beats[i]);
    endfunction

    task check_beat(sle_pkg::char_t ch, logic last);
      beat_t exp_b;
      checked++;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat char=%h last=%b", ch, last));
      end else begin
        exp_b = pending_beats.pop_front();
        if (ch !== exp_b.ch) begin
          report_mismatch($sformatf("beat %0d out_char=%h want %h", checked, ch, exp_b.ch));
        end
        if (last !== exp_b.last) begin
          report_mismatch($sformatf("beat %0d last=%b want %b", checked, last, exp_b.last));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  sle_in_if  in_bus();
  sle_out_if out_bus();
  sle_cfg_if cfg_bus();

  string_literal_escaper_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  escape_scoreboard sb = new();
  item_t       stim[$];
  logic        cur_mode = 1'b0;
  int          rx_style = 0;
  int unsigned rx_tick = 0;
  int          stall_left = 0;
  int unsigned cycles = 0;
  int          items_sent = 0;
  int          cfg_writes = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles,
               sb.pending_beats.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      sb.check_beat(out_bus.out_char, out_bus.last);
    end
  end

  // receiver stall pattern
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      case (rx_style)
        0: out_bus.ready = 1'b1;
        1: out_bus.ready = ($urandom_range(0, 99) < 70);
        2: begin
          rx_tick++;
          out_bus.ready = (rx_tick % 9) < 5;
        end
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_bus.ready = 1'b0;
          end else if ($urandom_range(0, 99) < 15) begin
            stall_left = $urandom_range(1, 8);
            out_bus.ready = 1'b0;
          end else begin
            out_bus.ready = 1'b1;
          end
        end
      endcase
    end
  end

  function automatic sle_pkg::char_t rand_code_point();
    sle_pkg::char_t pairs[9] = '{21'h5C, 21'h22, 21'h0A, 21'h07, 21'h08, 21'h09,
                                 21'h0B, 21'h0D, 21'h0C};
    sle_pkg::char_t hexes[5] = '{sle_pkg::HEX_DEL, sle_pkg::HEX_PAD, sle_pkg::HEX_SURL,
                                 sle_pkg::HEX_PUA, sle_pkg::HEX_MAX};
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return pairs[$urandom_range(0, 8)];
    if (sel < 27) return sle_pkg::char_t'($urandom_range(0, 31));
    if (sel < 37) return hexes[$urandom_range(0, 4)];
    if (sel < 67) return sle_pkg::char_t'($urandom_range(32, 126));
    if (sel < 90) return sle_pkg::char_t'($urandom_range(0, 21'h10FFFF));
    return sle_pkg::char_t'($urandom_range(21'h110000, 21'h1FFFFF));
  endfunction

  // Mostly well-formed strings with random content, plus stray commands.
  task fill_random(int n);
    item_t it;
    int    len;
    while (stim.size() < n) begin
      if ($urandom_range(0, 99) < 12) begin
        it.cmd = sle_pkg::cmd_t'($urandom_range(0, 3));
        it.cp  = sle_pkg::char_t'($urandom_range(0, 21'h1FFFFF));
        stim.push_back(it);
      end else begin
        it.cp = sle_pkg::char_t'($urandom);
        if ($urandom_range(0, 9) != 0) begin
          it.cmd = sle_pkg::CMD_BEGIN; stim.push_back(it);
        end
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
          it.cmd = sle_pkg::CMD_CHAR;
          it.cp  = rand_code_point();
          stim.push_back(it);
        end
        it.cp = sle_pkg::char_t'($urandom);
        if ($urandom_range(0, 9) != 0) begin
          it.cmd = sle_pkg::CMD_END; stim.push_back(it);
        end
      end
    end
  endtask

  task add_item(sle_pkg::cmd_t cmd, sle_pkg::char_t cp);
    item_t it;
    it.cmd = cmd;
    it.cp  = cp;
    stim.push_back(it);
  endtask

  task wait_idle();
    while (sb.pending_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task write_mode(logic m);
    cfg_bus.valid        = 1'b1;
    cfg_bus.display_mode = m;
    do @(posedge clk); while (!cfg_bus.ready);
    cur_mode = m;
    cfg_writes++;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Drains stim in bursts; called and returns at a falling edge.
  task drive_items(bit gaps_on);
    item_t it;
    int    burst_left;
    int    gap;
    burst_left = 0;
    while (stim.size() > 0) begin
      if (burst_left == 0) begin
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
          in_bus.valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      it = stim.pop_front();
      in_bus.valid      = 1'b1;
      in_bus.command    = it.cmd;
      in_bus.code_point = it.cp;
      do @(posedge clk); while (!in_bus.ready);
      sb.note_item(it.cmd, it.cp, cur_mode);
      items_sent++;
      burst_left--;
      @(negedge clk);
    end
    in_bus.valid = 1'b0;
  endtask

  task run_phase(logic m, int style, bit gaps_on);
    wait_idle();
    write_mode(m);
    rx_style = style;
    drive_items(gaps_on);
  endtask

  initial begin
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.command       = sle_pkg::CMD_CHAR;
    in_bus.code_point    = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.display_mode = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // write mode: every pair escape, hex escapes, passthrough, out of range
    add_item(sle_pkg::CMD_BEGIN, 21'h1FFFFF);
    add_item(sle_pkg::CMD_CHAR, 21'h5C);
    add_item(sle_pkg::CMD_CHAR, 21'h22);
    add_item(sle_pkg::CMD_CHAR, 21'h0A);
    add_item(sle_pkg::CMD_CHAR, 21'h07);
    add_item(sle_pkg::CMD_CHAR, 21'h08);
    add_item(sle_pkg::CMD_CHAR, 21'h09);
    add_item(sle_pkg::CMD_CHAR, 21'h0B);
    add_item(sle_pkg::CMD_CHAR, 21'h0D);
    add_item(sle_pkg::CMD_CHAR, 21'h0C);
    add_item(sle_pkg::CMD_CHAR, 21'h00);
    add_item(sle_pkg::CMD_CHAR, sle_pkg::HEX_DEL);
    add_item(sle_pkg::CMD_CHAR, sle_pkg::HEX_PAD);
    add_item(sle_pkg::CMD_CHAR, sle_pkg::HEX_SURL);
    add_item(sle_pkg::CMD_CHAR, sle_pkg::HEX_PUA);
    add_item(sle_pkg::CMD_CHAR, sle_pkg::HEX_MAX);
    add_item(sle_pkg::CMD_CHAR, 21'h41);
    add_item(sle_pkg::CMD_CHAR, 21'h1FFFFF);
    add_item(sle_pkg::CMD_NONE, 21'h1FFFFF);
    add_item(sle_pkg::CMD_END, 21'h0);
    run_phase(1'b0, 0, 1'b0);

    // display mode: raw chars, quotes dropped, unused command
    add_item(sle_pkg::CMD_BEGIN, 21'h0);
    add_item(sle_pkg::CMD_CHAR, 21'h0A);
    add_item(sle_pkg::CMD_CHAR, 21'h1FFFFF);
    add_item(sle_pkg::CMD_END, 21'h1FFFFF);
    add_item(sle_pkg::CMD_NONE, 21'h0);
    run_phase(1'b1, 1, 1'b1);

    fill_random(PHASE_ITEMS);
    run_phase(1'b0, 1, 1'b1);
    fill_random(PHASE_ITEMS);
    run_phase(1'b1, 2, 1'b1);
    fill_random(PHASE_ITEMS);
    run_phase(1'b0, 3, 1'b1);
    fill_random(PHASE_ITEMS);
    run_phase(1'b0, 0, 1'b0);

    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (sb.pending_beats.size() != 0) begin
      sb.report_mismatch($sformatf("%0d expected beats never came", sb.pending_beats.size()));
    end

    $display("ran %0d input beats, %0d output beats, %0d mode writes, both modes",
             items_sent, sb.checked, cfg_writes);
    $display("under bursty input and four output stall patterns; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
